FILE: hdl/picc_pkg.sv
// Shared types and constants of the predicate interval cover check.
// No dependencies; every file of the block but picc_fifo imports this package.
`timescale 1ns / 1ps

package picc_pkg;

	localparam int POS_W    = 10;
	localparam int MASK_W   = 64;
	localparam int EPOCH_W  = 8;
	localparam int CQ_DEPTH = 4;
	localparam int OQ_DEPTH = 2;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [MASK_W-1:0]  mask_t;
	typedef logic [EPOCH_W-1:0] epoch_t;

	localparam epoch_t EPOCH_MAX = '1;

	typedef struct packed {
		logic  carry;
		logic  zstar;
		logic  from_zero;
		pos_t  from_pos;
		pos_t  to_pos;
		logic  to_is_rend;
		mask_t mask;
		logic  doc_start;
		logic  rend_zero;
		logic  last;
		logic  fail;
	} cmd_t;

	typedef struct packed {
		logic  hit;
		mask_t subqueries;
	} res_t;

endpackage

FILE: hdl/picc_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module picc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/picc_front.sv
// Front end: takes each interval item, runs the gap check and the highest end,
// and turns the item into a store command. Depends on picc_pkg.
`timescale 1ns / 1ps

module picc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  picc_pkg::pos_t interval_begin,
	input  picc_pkg::pos_t interval_stop,
	input  picc_pkg::mask_t subquery_mask,
	input  picc_pkg::pos_t range_end,
	input  logic           first_item,
	input  logic           last_item,
	output picc_pkg::cmd_t cmd
);

	import picc_pkg::*;

	pos_t highest_end_q;
	pos_t doc_range_end_q;
	logic failed_q;

	pos_t he;
	pos_t dre;
	logic fl;
	logic zstar;
	logic gap;
	logic carry;
	pos_t begin_m1;
	pos_t upper;
	pos_t he_n;

	always_comb begin
		he       = first_item ? POS_W'(1) : highest_end_q;
		dre      = first_item ? range_end : doc_range_end_q;
		fl       = first_item ? 1'b0 : failed_q;
		begin_m1 = interval_begin - POS_W'(1);
		zstar    = interval_begin > interval_stop;
		if (zstar) begin
			gap = he < interval_stop;
		end else begin
			gap = (interval_begin == '0) || (he < begin_m1);
		end
		carry = !fl && !gap;
		upper = zstar ? interval_begin : interval_stop;
		he_n  = (carry && (upper > he)) ? upper : he;

		cmd.carry      = carry;
		cmd.zstar      = zstar;
		cmd.from_pos   = zstar ? interval_stop : begin_m1;
		cmd.from_zero  = zstar ? (interval_stop == '0) : (begin_m1 == '0);
		cmd.to_pos     = upper;
		cmd.to_is_rend = (upper == dre);
		cmd.mask       = subquery_mask;
		cmd.doc_start  = first_item;
		cmd.rend_zero  = (range_end == '0);
		cmd.last       = last_item;
		cmd.fail       = fl || gap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_end_q   <= POS_W'(1);
			doc_range_end_q <= '0;
			failed_q        <= 1'b0;
		end else if (accept) begin
			highest_end_q   <= he_n;
			doc_range_end_q <= dre;
			failed_q        <= fl || gap;
		end
	end

endmodule

FILE: hdl/picc_back.sv
// Back end: marker store with epoch tags, one read-modify-write per command,
// forwarding of the latest write, and the clearing pass. Depends on picc_pkg.
`timescale 1ns / 1ps

module picc_back #(
	parameter int RANGE_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  picc_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           res_push,
	output picc_pkg::res_t res,
	input  logic           res_full,
	output logic           clearing
);

	import picc_pkg::*;

	localparam int MEM_DEPTH = (RANGE_DEPTH < (1 << POS_W)) ? RANGE_DEPTH : (1 << POS_W);
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

	typedef struct packed {
		epoch_t tag;
		mask_t  marker;
	} entry_t;

	entry_t        mem [MEM_DEPTH];

	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;
	epoch_t        epoch_q;
	logic          valid_s2;
	cmd_t          cmd_s2;
	entry_t        rd_from_s2;
	entry_t        rd_to_s2;
	logic          lw_valid_q;
	logic [AW-1:0] lw_addr_q;
	entry_t        lw_entry_q;
	mask_t         marker0_q;
	logic          visited0_q;
	mask_t         rend_q;

	logic          need_clear;
	logic          clr_start;
	logic          s2_adv;
	logic          s2_free;
	logic [AW-1:0] from_addr;
	logic [AW-1:0] to_addr;
	entry_t        from_ent;
	entry_t        to_ent;
	logic          from_ok;
	logic          to_ok;
	logic          epoch_live;
	logic          from_vis;
	mask_t         from_mk;
	mask_t         to_mk;
	mask_t         bits;
	mask_t         m0;
	logic          v0;
	logic          do_write;
	entry_t        wr_entry;
	mask_t         rend_base;
	mask_t         rend_new;

	assign clearing   = clearing_q;
	assign need_clear = cmd_valid && cmd.doc_start && (epoch_q == EPOCH_MAX);
	assign clr_start  = need_clear && !clearing_q && !valid_s2;
	assign s2_adv     = valid_s2 && (!cmd_s2.last || !res_full);
	assign s2_free    = !valid_s2 || s2_adv;
	assign cmd_pop    = cmd_valid && !clearing_q && !need_clear && s2_free;

	always_comb begin
		from_addr  = AW'(cmd_s2.from_pos);
		to_addr    = AW'(cmd_s2.to_pos);
		from_ok    = 32'(cmd_s2.from_pos) < MEM_DEPTH;
		to_ok      = 32'(cmd_s2.to_pos) < MEM_DEPTH;
		epoch_live = (epoch_q != '0);
		from_ent   = (lw_valid_q && (lw_addr_q == from_addr)) ? lw_entry_q : rd_from_s2;
		to_ent     = (lw_valid_q && (lw_addr_q == to_addr)) ? lw_entry_q : rd_to_s2;
		m0         = cmd_s2.doc_start ? '1 : marker0_q;
		v0         = cmd_s2.doc_start || visited0_q;

		if (cmd_s2.from_zero) begin
			from_vis = v0;
			from_mk  = m0;
		end else begin
			from_vis = from_ok && epoch_live && (from_ent.tag == epoch_q);
			from_mk  = from_vis ? from_ent.marker : '0;
		end
		to_mk = (epoch_live && (to_ent.tag == epoch_q)) ? to_ent.marker : '0;

		bits     = cmd_s2.zstar ? ~from_mk : (from_mk & cmd_s2.mask);
		do_write = cmd_s2.carry && from_vis && to_ok;
		wr_entry = '{tag: epoch_q, marker: to_mk | bits};

		if (cmd_s2.doc_start) begin
			rend_base = cmd_s2.rend_zero ? '1 : '0;
		end else begin
			rend_base = rend_q;
		end
		rend_new = (do_write && cmd_s2.to_is_rend) ? (rend_base | bits) : rend_base;

		res.hit        = !cmd_s2.fail && (rend_new != '0);
		res.subqueries = cmd_s2.fail ? '0 : rend_new;
	end

	assign res_push = s2_adv && cmd_s2.last;

	// store and read ports
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (s2_adv && do_write) begin
			mem[to_addr] <= wr_entry;
		end
		if (cmd_pop) begin
			rd_from_s2 <= mem[AW'(cmd.from_pos)];
			rd_to_s2   <= mem[AW'(cmd.to_pos)];
			cmd_s2     <= cmd;
		end
		if (s2_adv && do_write) begin
			lw_addr_q  <= to_addr;
			lw_entry_q <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			epoch_q    <= '0;
			valid_s2   <= 1'b0;
			lw_valid_q <= 1'b0;
			marker0_q  <= '0;
			visited0_q <= 1'b0;
			rend_q     <= '0;
		end else begin
			if (clearing_q) begin
				lw_valid_q <= 1'b0;
				if (clr_cnt_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
					clr_cnt_q  <= '0;
					epoch_q    <= '0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end else if (clr_start) begin
				clearing_q <= 1'b1;
			end else if (cmd_pop && cmd.doc_start) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if (s2_adv && do_write) begin
				lw_valid_q <= 1'b1;
			end
			if (s2_free) begin
				valid_s2 <= cmd_pop;
			end
			if (s2_adv) begin
				marker0_q  <= m0;
				visited0_q <= v0;
				rend_q     <= rend_new;
			end
		end
	end

endmodule

FILE: hdl/predicate_interval_cover_check_core.sv
// Top level of the predicate interval cover check.
// Depends on picc_pkg, picc_front, picc_fifo and picc_back.
//
// Input side is a queue: drive one interval per item on the payload ports and
// raise push; the item is taken at a clock edge with push high and full low.
// Items of one document come in ascending packed order, the first with
// first_item set (range_end is taken from it) and the last with last_item set.
// Result side is a queue too: while empty is low, hit and subqueries show the
// oldest result, taken at an edge with pop high. Only a last item yields one.
// Throughput: one item per cycle while full is low, set by the single
// read-modify-write of the marker store per item, with the latest write
// forwarded to the next read. Store entries carry a document tag, so a new
// document needs no clearing. After reset, and again once every 255 documents
// when the tag wraps, a clearing pass runs over all min(RANGE_DEPTH, 1024)
// store entries; full stays high meanwhile. When pop is held low, results
// collect in a two-entry queue, then the store pipeline holds and a
// four-entry command queue fills before full rises.

`timescale 1ns / 1ps

module predicate_interval_cover_check_core #(
	parameter int RANGE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  picc_pkg::pos_t  interval_begin,
	input  picc_pkg::pos_t  interval_stop,
	input  picc_pkg::mask_t subquery_mask,
	input  picc_pkg::pos_t  range_end,
	input  logic            first_item,
	input  logic            last_item,
	output logic            empty,
	input  logic            pop,
	output logic            hit,
	output picc_pkg::mask_t subqueries
);

	import picc_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cq_full;
	logic cq_empty;
	logic cmd_pop;
	logic clearing;
	logic accept;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic oq_full;

	assign full   = cq_full || clearing;
	assign accept = push && !full;

	picc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.interval_begin (interval_begin),
		.interval_stop  (interval_stop),
		.subquery_mask  (subquery_mask),
		.range_end      (range_end),
		.first_item     (first_item),
		.last_item      (last_item),
		.cmd            (cmd_in)
	);

	picc_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CQ_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (cmd_in),
		.full   (cq_full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cq_empty)
	);

	picc_back #(
		.RANGE_DEPTH (RANGE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cq_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (oq_full),
		.clearing  (clearing)
	);

	picc_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OQ_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (oq_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign hit        = res_out.hit;
	assign subqueries = res_out.subqueries;

endmodule

FILE: tb/predicate_interval_cover_check_core_tb.sv
// Testbench for predicate_interval_cover_check_core: a directed table, then random documents,
// with each result checked against the table's own value or an in-bench coverage predictor.
// Depends on picc_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module predicate_interval_cover_check_core_tb;
	import picc_pkg::*;

	localparam int    DEPTH     = 1024;
	localparam mask_t ALL_ONES  = '1;
	localparam mask_t MASK_A    = 64'hDEAD_BEEF_0123_4567;
	localparam mask_t MASK_B    = 64'h8000_0000_0000_0001;
	localparam mask_t ALT_BITS  = 64'h5555_5555_5555_5555;
	localparam int    ITEM_GOAL = 1950;

	typedef struct {
		pos_t  b;
		pos_t  e;
		mask_t m;
		pos_t  r;
		logic  f;
		logic  l;
		logic  typed;
		logic  h;
		mask_t s;
	} plan_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  push = 1'b0;
	logic  full;
	pos_t  interval_begin = '0;
	pos_t  interval_stop = '0;
	mask_t subquery_mask = '0;
	pos_t  range_end = '0;
	logic  first_item = 1'b0;
	logic  last_item = 1'b0;
	logic  empty;
	logic  pop = 1'b0;
	logic  hit;
	mask_t subqueries;

	mask_t cov_marker [DEPTH];
	logic  cov_seen [DEPTH];
	pos_t  reach;
	pos_t  doc_rend;
	logic  doc_failed;

	res_t  pending_results [$];
	int    errors = 0;
	int    items_sent = 0;
	int    results_taken = 0;
	logic  sender_brisk = 1'b0;
	logic  receiver_brisk = 1'b0;

	plan_row_t plan [22];

	predicate_interval_cover_check_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.interval_begin(interval_begin), .interval_stop(interval_stop),
		.subquery_mask(subquery_mask), .range_end(range_end),
		.first_item(first_item), .last_item(last_item),
		.empty(empty), .pop(pop), .hit(hit), .subqueries(subqueries)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("predicate_interval_cover_check_core verification failed");
		$finish;
	end

	function automatic logic cover_step(input pos_t b, input pos_t e, input mask_t m,
			input pos_t r, input logic f, input logic l, output res_t res);
		res = '{hit: 1'b0, subqueries: '0};
		if (f) begin
			for (int i = 0; i < DEPTH; i++) begin
				cov_marker[i] = '0;
				cov_seen[i] = 1'b0;
			end
			cov_marker[0] = ALL_ONES;
			cov_seen[0] = 1'b1;
			reach = 10'd1;
			doc_failed = 1'b0;
			doc_rend = r;
		end
		if (!doc_failed) begin
			if (b > e) begin
				if (reach < e) begin
					doc_failed = 1'b1;
				end else begin
					if (cov_seen[e]) begin
						cov_seen[b] = 1'b1;
						cov_marker[b] |= ~cov_marker[e];
					end
					if (b > reach) reach = b;
				end
			end else if (b == 0 || reach < b - 10'd1) begin
				doc_failed = 1'b1;
			end else begin
				if (cov_seen[b - 10'd1]) begin
					cov_seen[e] = 1'b1;
					cov_marker[e] |= cov_marker[b - 10'd1] & m;
				end
				if (e > reach) reach = e;
			end
		end
		if (!l) return 1'b0;
		if (!doc_failed) begin
			res.subqueries = cov_marker[doc_rend];
			res.hit = res.subqueries != 0;
		end
		return 1'b1;
	endfunction

	task automatic offer_interval(input pos_t b, input pos_t e, input mask_t m, input pos_t r,
			input logic f, input logic l, input logic typed, input res_t want);
		res_t predicted;
		int   gap;
		@(negedge clk);
		push <= 1'b1;
		interval_begin <= b;
		interval_stop <= e;
		subquery_mask <= m;
		range_end <= r;
		first_item <= f;
		last_item <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		if (cover_step(b, e, m, r, f, l, predicted))
			pending_results.push_back(typed ? want : predicted);
		gap = sender_brisk ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic mask_t draw_mask();
		case ($urandom_range(0, 4))
			0: return ALL_ONES;
			1: return mask_t'(1) << $urandom_range(0, 63);
			2: return ~(mask_t'(1) << $urandom_range(0, 63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_document();
		int   rend, n, step, b, e, hi, nb;
		logic zstar, drop_last;
		res_t none;
		none = '{hit: 1'b0, subqueries: '0};
		rend = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
		n = $urandom_range(1, 8);
		step = rend / n + 2;
		drop_last = $urandom_range(0, 19) == 0;
		b = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 3) : 1;
		hi = 1;
		for (int k = 0; k < n; k++) begin
			zstar = b >= 1 && $urandom_range(0, 5) == 0;
			if (zstar) begin
				e = $urandom_range(0, (hi < b - 1) ? hi : b - 1);
				if ($urandom_range(0, 15) == 0) e = b - 1;
				if (b > hi) hi = b;
			end else begin
				e = b + $urandom_range(0, step);
				if (k == n - 1 && rend >= b) e = rend;
				if (e > 1023) e = 1023;
				if (e > hi) hi = e;
			end
			offer_interval(pos_t'(b), pos_t'(e), draw_mask(), pos_t'(rend),
				k == 0, k == n - 1 && !drop_last, 1'b0, none);
			nb = ($urandom_range(0, 19) == 0) ? hi + $urandom_range(2, 20)
				: $urandom_range(b, hi + 1);
			b = (nb > 1023) ? 1023 : nb;
		end
	endtask

	initial begin
		res_t want;
		int   docs;
		for (int i = 0; i < DEPTH; i++) begin
			cov_marker[i] = '0;
			cov_seen[i] = 1'b0;
		end
		reach = 10'd1;
		doc_rend = '0;
		doc_failed = 1'b0;
		plan = '{
			'{10'd0,    10'd0,    ALL_ONES, 10'd0,    1'b0, 1'b1, 1'b1, 1'b0, '0},
			'{10'd1,    10'd5,    ALL_ONES, 10'd5,    1'b1, 1'b1, 1'b1, 1'b1, ALL_ONES},
			'{10'd1,    10'd1,    ALL_ONES, 10'd0,    1'b1, 1'b1, 1'b1, 1'b1, ALL_ONES},
			'{10'd0,    10'd3,    ALL_ONES, 10'd3,    1'b1, 1'b1, 1'b1, 1'b0, '0},
			'{10'd1,    10'd3,    MASK_A,   10'd10,   1'b1, 1'b0, 1'b0, 1'b0, '0},
			'{10'd6,    10'd10,   ALL_ONES, 10'd0,    1'b0, 1'b1, 1'b1, 1'b0, '0},
			'{10'd1,    10'd4,    MASK_A,   10'd9,    1'b1, 1'b0, 1'b0, 1'b0, '0},
			'{10'd9,    10'd4,    ALL_ONES, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, '0},
			'{10'd1,    10'd1023, '0,       10'd1023, 1'b1, 1'b1, 1'b1, 1'b0, '0},
			'{10'd1,    10'd1022, ALL_ONES, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, '0},
			'{10'd1023, 10'd1023, ALT_BITS, 10'd0,    1'b0, 1'b1, 1'b1, 1'b1, ALT_BITS},
			'{10'd5,    10'd0,    ALL_ONES, 10'd5,    1'b1, 1'b1, 1'b1, 1'b0, '0},
			'{10'd1,    10'd3,    MASK_B,   10'd5,    1'b1, 1'b0, 1'b0, 1'b0, '0},
			'{10'd3,    10'd5,    ALL_ONES, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0},
			'{10'd4,    10'd5,    ALL_ONES, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, '0},
			'{10'd1,    10'd2,    MASK_A,   10'd7,    1'b1, 1'b0, 1'b0, 1'b0, '0},
			'{10'd1,    10'd7,    MASK_B,   10'd7,    1'b1, 1'b0, 1'b0, 1'b0, '0},
			'{10'd8,    10'd9,    ALL_ONES, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, '0},
			'{10'd1000, 10'd1001, ALL_ONES, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0},
			'{10'd1001, 10'd1002, ALL_ONES, 10'd0,    1'b0, 1'b1, 1'b1, 1'b0, '0},
			'{10'd1,    10'd1,    '0,       10'd3,    1'b1, 1'b0, 1'b0, 1'b0, '0},
			'{10'd3,    10'd1,    ALL_ONES, 10'd0,    1'b0, 1'b1, 1'b1, 1'b1, ALL_ONES}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			want = '{hit: plan[i].h, subqueries: plan[i].s};
			offer_interval(plan[i].b, plan[i].e, plan[i].m, plan[i].r, plan[i].f, plan[i].l,
				plan[i].typed, want);
		end
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		docs = 0;
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 4) == 0) sender_brisk = ~sender_brisk;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3))
					offer_interval(pos_t'($urandom), pos_t'($urandom), {$urandom, $urandom},
						pos_t'($urandom), 1'($urandom), 1'($urandom), 1'b0, want);
			end
			send_document();
			docs++;
			if (docs == 150) begin
				@(negedge clk);
				push <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
		end
		@(negedge clk);
		push <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("predicate_interval_cover_check_core verification clean");
		else
			$display("predicate_interval_cover_check_core verification failed");
		$finish;
	end

	initial begin
		int   hold;
		res_t want;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) receiver_brisk = ~receiver_brisk;
			hold = receiver_brisk ? 0 : $urandom_range(0, 3);
			if (results_taken == 250) hold = 300;
			if (hold > 0) begin
				@(negedge clk);
				pop <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			results_taken++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result hit=%b subqueries=%h", $time, hit, subqueries);
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					errors++;
					$display("%0t: hit expected %b actual %b", $time, want.hit, hit);
				end
				if (subqueries !== want.subqueries) begin
					errors++;
					$display("%0t: subqueries expected %h actual %h", $time,
						want.subqueries, subqueries);
				end
			end
		end
	end

endmodule
